### src/ffha_pkg.sv
package ffha_pkg;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_INIT   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [31:0] POOL_BYTES_RST = 32'd33554432;
  localparam logic [6:0]  HDR_SIZE_RST   = 7'd16;

  localparam logic [0:0] REG_HEAP = 1'b0;
  localparam logic [0:0] REG_HDR  = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] request_size;
    logic [31:0] release_offset;
  } in_word_t;

  typedef struct packed {
    logic [31:0] payload_offset;
    logic [2:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ASCAN,
    S_AREAD,
    S_SHIFT,
    S_SPLIT,
    S_FSCAN,
    S_FREAD,
    S_MSCAN,
    S_MREAD,
    S_MPULL,
    S_DONE
  } state_t;

  // header clamp to 1..64
  function automatic logic [6:0] hdr_eff(input logic [6:0] h);
    logic [6:0] r;
    r = h;
    if (h == 7'd0) r = 7'd1;
    else if (h > 7'd64) r = 7'd64;
    return r;
  endfunction

endpackage

### src/ffha_regs.sv
module ffha_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [31:0] pool_bytes,
  output logic [6:0]  header_size
);
  import ffha_pkg::*;

  logic [31:0] heap_r;
  logic [6:0]  hdr_r;
  logic        wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= POOL_BYTES_RST;
      hdr_r  <= HDR_SIZE_RST;
    end else if (wr) begin
      if (paddr[2] == REG_HEAP) heap_r <= pwdata;
      else                      hdr_r  <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_HEAP) prdata = heap_r;
      else                      prdata = {25'd0, hdr_r};
    end
  end

  assign pool_bytes  = heap_r;
  assign header_size = hdr_r;
endmodule

### src/first_fit_heap_allocator_core.sv
// channel | ports                              | direction
// config  | psel penable pwrite paddr pwdata   | in, apb write/read, pready tied high
// input   | in_start in_busy in_word           | word taken when start && !busy
// result  | out_valid out_word                 | one cycle strobe, cannot be stalled
// steps: init and zero/null go straight to the result; alloc scans entries, then
// shifts later entries up one slot to split; free scans entries, then runs a merge pass
// reset: synchronous active low, table holds one free chunk of the reset pool size
// busy stays high from accept until the result strobe; results are never held off
module first_fit_heap_allocator_core #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_start,
  output logic                in_busy,
  input  ffha_pkg::in_word_t  in_word,
  output logic                out_valid,
  output ffha_pkg::out_word_t out_word
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);

  logic [31:0] pool_bytes;
  logic [6:0]  header_size;

  assign pready = 1'b1;

  ffha_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pool_bytes, .header_size
  );

  // chunk table: start and bytes in one memory, in-use marks in flops
  logic [63:0]         mem [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] used_r, used_nxt;
  logic [63:0]         rd_r;
  logic [IW-1:0]       ra, wa;
  logic [63:0]         wd;
  logic                we;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  state_t      st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  in_word_t    req_r, req_nxt;
  logic [31:0] acc_r, acc_nxt;   // held bytes during split and merge
  logic [31:0] acs_r, acs_nxt;   // held start during split and merge
  logic [2:0]  sta_r, sta_nxt;
  logic [31:0] off_r, off_nxt;
  logic [32:0] sz_exact, sz_split;
  logic [6:0]  h;
  logic [31:0] e_start, e_bytes;

  assign h        = hdr_eff(header_size);
  assign sz_exact = {1'b0, req_r.request_size} + {26'd0, h};
  assign sz_split = sz_exact + {26'd0, h};
  assign e_start  = rd_r[63:32];
  assign e_bytes  = rd_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= CW'(1);
      used_r <= '0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
    end
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    req_r <= req_nxt;
    acc_r <= acc_nxt;
    acs_r <= acs_nxt;
    sta_r <= sta_nxt;
    off_r <= off_nxt;
  end

  // entry zero after reset: start 0, bytes of the reset pool size; tracked by a flag
  logic init0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) init0_r <= 1'b1;
    else if (we && wa == '0) init0_r <= 1'b0;
  end
  logic [63:0] rdv;
  logic        rd0_r;
  always_ff @(posedge clk) rd0_r <= (ra == '0) && init0_r;
  assign rdv = rd0_r ? {32'd0, POOL_BYTES_RST} : rd_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; used_nxt = used_r;
    i_nxt = i_r; j_nxt = j_r; req_nxt = req_r;
    acc_nxt = acc_r; acs_nxt = acs_r; sta_nxt = sta_r; off_nxt = off_r;
    ra = i_r[IW-1:0]; wa = '0; wd = '0; we = 1'b0;
    out_valid = 1'b0;
    out_word  = '{payload_offset: off_r, status: sta_r};
    unique case (st_r)
      S_IDLE: begin
        if (in_start) begin
          req_nxt = in_word; i_nxt = '0; off_nxt = '0; sta_nxt = ST_OK;
          ra = '0;
          st_nxt = S_DONE;
          priority if (in_word.action == ACT_INIT) begin
            we = 1'b1; wa = '0; wd = {32'd0, pool_bytes};
            used_nxt = '0; cnt_nxt = CW'(1);
          end else if (in_word.action == ACT_ALLOC) begin
            if (in_word.request_size == 0) sta_nxt = ST_NULL;
            else st_nxt = S_AREAD;
          end else if (in_word.action == ACT_FREE) begin
            if (in_word.release_offset == 0) sta_nxt = ST_NULL;
            else st_nxt = S_FREAD;
          end else begin
          end
        end
      end
      S_AREAD: st_nxt = S_ASCAN;
      S_ASCAN: begin
        if (i_r >= cnt_r) begin
          sta_nxt = ST_NOFIT; st_nxt = S_DONE;
        end else if (!used_r[i_r[IW-1:0]] && {1'b0, rdv[31:0]} >= sz_split) begin
          if (cnt_r >= CW'(MAX_CHUNKS)) begin
            sta_nxt = ST_FULL; st_nxt = S_DONE;
          end else begin
            acs_nxt = rdv[63:32]; acc_nxt = rdv[31:0];
            j_nxt = cnt_r; st_nxt = S_SHIFT;
            ra = IW'(cnt_r - CW'(1));
          end
        end else if (!used_r[i_r[IW-1:0]] && {1'b0, rdv[31:0]} == sz_exact) begin
          used_nxt[i_r[IW-1:0]] = 1'b1;
          off_nxt = rdv[63:32] + {25'd0, h};
          st_nxt = S_DONE;
        end else begin
          i_nxt = i_r + CW'(1); ra = IW'(i_r + CW'(1)); st_nxt = S_AREAD;
        end
      end
      S_SHIFT: begin
        // rd holds entry j-1 when j > i+1
        if (j_r > i_r + CW'(1)) begin
          we = 1'b1; wa = j_r[IW-1:0]; wd = rdv;
          used_nxt[j_r[IW-1:0]] = used_r[IW'(j_r - CW'(1))];
          j_nxt = j_r - CW'(1);
          ra = IW'(j_r - CW'(2));
          st_nxt = S_SHIFT;
          if (j_r - CW'(1) > i_r + CW'(1)) st_nxt = S_SHIFT;
        end else begin
          we = 1'b1; wa = IW'(i_r + CW'(1));
          wd = {acs_r + sz_exact[31:0], acc_r - sz_exact[31:0]};
          used_nxt[IW'(i_r + CW'(1))] = 1'b0;
          st_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        we = 1'b1; wa = i_r[IW-1:0]; wd = {acs_r, sz_exact[31:0]};
        used_nxt[i_r[IW-1:0]] = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        off_nxt = acs_r + {25'd0, h};
        st_nxt = S_DONE;
      end
      S_FREAD: st_nxt = S_FSCAN;
      S_FSCAN: begin
        if (i_r >= cnt_r) begin
          sta_nxt = ST_UNKNOWN; st_nxt = S_DONE;
        end else if ({1'b0, rdv[63:32]} + {26'd0, h} == {1'b0, req_r.release_offset}) begin
          used_nxt[i_r[IW-1:0]] = 1'b0;
          i_nxt = '0; j_nxt = CW'(1); ra = '0; st_nxt = S_MREAD;
        end else begin
          i_nxt = i_r + CW'(1); ra = IW'(i_r + CW'(1)); st_nxt = S_FREAD;
        end
      end
      // merge: compact table in one pass; i = write slot, j = read slot
      S_MREAD: begin
        // rd = entry i; load accumulator
        acs_nxt = rdv[63:32]; acc_nxt = rdv[31:0];
        ra = j_r[IW-1:0];
        st_nxt = S_MPULL;
        if (j_r >= cnt_r) begin
          cnt_nxt = i_r + CW'(1); st_nxt = S_DONE;
        end
      end
      S_MPULL: begin
        // keep the read slot on the port
        ra = j_r[IW-1:0];
        st_nxt = S_MSCAN;
      end
      S_MSCAN: begin
        // rd = entry j, accumulator is slot i
        if (!used_r[i_r[IW-1:0]] && !used_r[j_r[IW-1:0]]) begin
          acc_nxt = acc_r + rdv[31:0];
          we = 1'b1; wa = i_r[IW-1:0]; wd = {acs_r, acc_r + rdv[31:0]};
        end else begin
          i_nxt = i_r + CW'(1);
          we = 1'b1; wa = IW'(i_r + CW'(1)); wd = rdv;
          used_nxt[IW'(i_r + CW'(1))] = used_r[j_r[IW-1:0]];
          acs_nxt = rdv[63:32]; acc_nxt = rdv[31:0];
        end
        j_nxt = j_r + CW'(1);
        ra = IW'(j_r + CW'(1));
        if (j_r + CW'(1) >= cnt_r) begin
          cnt_nxt = ((!used_r[i_r[IW-1:0]] && !used_r[j_r[IW-1:0]]) ? i_r : i_r + CW'(1))
                    + CW'(1);
          st_nxt = S_DONE;
        end else st_nxt = S_MPULL;
      end
      S_DONE: begin
        out_valid = 1'b1;
        out_word  = '{payload_offset: (sta_r == ST_OK) ? off_r : 32'd0, status: sta_r};
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_busy = (st_r != S_IDLE);
endmodule
